@@ rtl/mlq_pkg.sv @@
package mlq_pkg;

   localparam int NumPrioDefault   = 8;
   localparam int QueueDepthDefault = 16;
   localparam int IdWidth          = 8;
   localparam int PrioWidth        = 3;
   localparam int RemWidth         = 12;
   localparam int SliceWidth       = 10;
   localparam logic [SliceWidth-1:0] SliceReset = 10'd2;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_FETCH   = 1'b1
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [IdWidth-1:0]   task_id;
      logic [PrioWidth-1:0] priority_req;
      logic [RemWidth-1:0]  remaining;
   } req_type;

   typedef struct packed {
      logic                  dispatched;
      logic [IdWidth-1:0]    out_task_id;
      logic [PrioWidth-1:0]  out_priority;
      logic [SliceWidth-1:0] granted_slice;
      logic                  dropped;
   } rsp_type;

endpackage

@@ rtl/mlq_front.sv @@
module mlq_front #(
   parameter int NumPrio = mlq_pkg::NumPrioDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mlq_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_stall,
   output mlq_pkg::req_type q_data,
   output logic             q_bad_level
);

   localparam int QDepth = 2;

   mlq_pkg::req_type  buf_ff [QDepth];
   logic [QDepth-1:0] badl_ff;
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop, bad;

   assign bad       = 32'(req_data.priority_req) >= NumPrio;
   assign req_stall = cnt_ff == 2'(QDepth);
   assign push      = req_valid && !req_stall;
   assign q_valid   = cnt_ff != 2'd0;
   assign pop       = q_valid && !q_stall;
   assign q_data    = buf_ff[rp_ff];
   assign q_bad_level = badl_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff]  <= req_data;
         badl_ff[wp_ff] <= bad;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDepth)) else $error("queue overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QDepth) |-> !push) else $error("push while full");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count step");
`endif

endmodule

@@ rtl/mlq_back.sv @@
module mlq_back #(
   parameter int NumPrio    = mlq_pkg::NumPrioDefault,
   parameter int QueueDepth = mlq_pkg::QueueDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_stall,
   input  mlq_pkg::req_type               q_data,
   input  logic                           q_bad_level,
   input  logic [mlq_pkg::SliceWidth-1:0] slice_limit,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mlq_pkg::rsp_type               rsp_data
);

   localparam int LvW  = (NumPrio > 1) ? $clog2(NumPrio) : 1;
   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam int BudW = $clog2(NumPrio + 1);
   localparam int AdrW = LvW + PtrW;
   localparam int EntW = mlq_pkg::IdWidth + mlq_pkg::RemWidth;

   logic [EntW-1:0] mem [NumPrio * (2 ** PtrW)];
   logic [EntW-1:0] rd_ff;

   logic [PtrW-1:0] head_ff [NumPrio];
   logic [PtrW-1:0] tail_ff [NumPrio];
   logic [CntW-1:0] cnt_ff  [NumPrio];
   logic [BudW-1:0] bud_ff  [NumPrio];
   logic            armed_ff;

   logic            busy_ff;
   logic [LvW-1:0]  sel_ff;
   logic [BudW-1:0] selbud_ff;

   logic            out_v_ff;
   mlq_pkg::rsp_type out_ff;

   logic            take, found, wr_en, rd_en, finish;
   logic [LvW-1:0]  hit;
   logic [LvW-1:0]  lvl;
   logic            full;
   logic [AdrW-1:0] wr_adr, rd_adr;
   logic [mlq_pkg::RemWidth-1:0] rem, g1, grant;

   assign lvl  = LvW'(q_data.priority_req);
   assign full = q_bad_level || (cnt_ff[lvl] == CntW'(QueueDepth));

   always_comb begin
      found = 1'b0;
      hit   = '0;
      for (int i = NumPrio - 1; i >= 0; i--) begin
         if (bud_ff[i] != '0 && cnt_ff[i] != '0) begin
            found = 1'b1;
            hit   = LvW'(i);
         end
      end
   end

   assign q_stall = busy_ff || (out_v_ff && rsp_stall);
   assign take    = q_valid && !q_stall;
   assign wr_en   = take && q_data.operation == mlq_pkg::OP_ENQUEUE && !full;
   assign rd_en   = take && q_data.operation == mlq_pkg::OP_FETCH && found;
   assign finish  = busy_ff;
   assign wr_adr  = {lvl, tail_ff[lvl]};
   assign rd_adr  = {hit, head_ff[hit]};

   assign rem   = rd_ff[mlq_pkg::RemWidth-1:0];
   assign g1    = (rem > mlq_pkg::RemWidth'(selbud_ff)) ?
                  mlq_pkg::RemWidth'(selbud_ff) : rem;
   assign grant = (g1 > mlq_pkg::RemWidth'(slice_limit)) ?
                  mlq_pkg::RemWidth'(slice_limit) : g1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_adr] <= {q_data.task_id, q_data.remaining};
      end
      if (rd_en) begin
         rd_ff     <= mem[rd_adr];
         sel_ff    <= hit;
         selbud_ff <= bud_ff[hit];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumPrio; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
            bud_ff[i]  <= BudW'(NumPrio - i);
         end
         armed_ff <= 1'b0;
         busy_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (out_v_ff && !rsp_stall && !finish && !(take && !rd_en)) begin
            out_v_ff <= 1'b0;
         end
         if (wr_en) begin
            tail_ff[lvl] <= (32'(tail_ff[lvl]) == QueueDepth - 1) ? '0 : tail_ff[lvl] + 1'b1;
            cnt_ff[lvl]  <= cnt_ff[lvl] + 1'b1;
         end
         if (take) begin
            priority if (q_data.operation == mlq_pkg::OP_ENQUEUE) begin
               out_v_ff <= 1'b1;
               out_ff   <= '{dispatched: 1'b0, out_task_id: '0, out_priority: '0,
                             granted_slice: '0, dropped: full};
            end else if (found) begin
               busy_ff <= 1'b1;
               head_ff[hit] <= (32'(head_ff[hit]) == QueueDepth - 1) ? '0 : head_ff[hit] + 1'b1;
               cnt_ff[hit]  <= cnt_ff[hit] - 1'b1;
               armed_ff     <= 1'b1;
            end else begin
               out_v_ff <= 1'b1;
               out_ff   <= '0;
               if (armed_ff) begin
                  for (int i = 0; i < NumPrio; i++) begin
                     bud_ff[i] <= BudW'(NumPrio - i);
                  end
               end
            end
         end
         if (finish) begin
            busy_ff        <= 1'b0;
            out_v_ff       <= 1'b1;
            bud_ff[sel_ff] <= selbud_ff - BudW'(grant);
            out_ff <= '{dispatched: 1'b1,
                        out_task_id: rd_ff[EntW-1:mlq_pkg::RemWidth],
                        out_priority: mlq_pkg::PrioWidth'(sel_ff),
                        granted_slice: mlq_pkg::SliceWidth'(grant),
                        dropped: 1'b0};
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff) else $error("fetch pipeline stuck");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> out_v_ff && out_ff.dispatched) else $error("dispatch lost");
   a_grant: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.dispatched |-> out_ff.granted_slice <= 10'(NumPrio))
      else $error("grant above budget");
`endif

endmodule

@@ rtl/mlq_budget_scheduler_core.sv @@
// multilevel queue dispatcher with per-level budgets
// req channel: req_valid / req_stall / req_data; operation enqueue or fetch
// rsp channel: rsp_valid / rsp_stall / rsp_data; exactly one item per request
// csr channel: csr_valid / csr_ready / csr_data writes slice_limit (always ready)
// a two-entry front queue decouples request intake from the back end
// enqueue: result passes the front queue, then the back-end output register
// fetch: result passes the front queue, then the task store read, which is
// registered, then the output register; a hit sets busy in the back end
// one enqueue or empty fetch per cycle; no new item is taken while a hit is busy
// the back end holds while a finished item waits under rsp_stall
// the front queue keeps taking items until both entries are full
// reset clears levels, restores budgets to NUM_PRIO minus level,
// sets slice_limit to 2; no clearing pass is needed
module mlq_budget_scheduler_core #(
   parameter int NumPrio    = mlq_pkg::NumPrioDefault,
   parameter int QueueDepth = mlq_pkg::QueueDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mlq_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mlq_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mlq_pkg::SliceWidth-1:0] csr_data
);

   logic [mlq_pkg::SliceWidth-1:0] slice_ff;
   logic             q_valid, q_stall, q_bad;
   mlq_pkg::req_type q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= mlq_pkg::SliceReset;
      end else if (csr_valid) begin
         slice_ff <= csr_data;
      end
   end

   mlq_front #(.NumPrio(NumPrio)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_stall, .q_data, .q_bad_level(q_bad)
   );

   mlq_back #(.NumPrio(NumPrio), .QueueDepth(QueueDepth)) u_back (
      .clock, .reset, .q_valid, .q_stall, .q_data, .q_bad_level(q_bad),
      .slice_limit(slice_ff), .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

@@ tb/mlq_checker.sv @@
module mlq_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  mlq_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  mlq_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [mlq_pkg::SliceWidth-1:0] csr_data,
   output int                             fail_count,
   output int                             pending_count,
   output int                             dispatch_count,
   output int                             drop_count
);
   localparam int NLev  = mlq_pkg::NumPrioDefault;
   localparam int Depth = mlq_pkg::QueueDepthDefault;

   logic [mlq_pkg::IdWidth-1:0]    fifo_id  [NLev][Depth];
   logic [mlq_pkg::RemWidth-1:0]   fifo_rem [NLev][Depth];
   int                             head [NLev];
   int                             tail [NLev];
   int                             fill [NLev];
   int                             budget [NLev];
   bit                             armed;
   logic [mlq_pkg::SliceWidth-1:0] slice_max;
   mlq_pkg::rsp_type               expected_q[$];

   function automatic mlq_pkg::rsp_type schedule(mlq_pkg::req_type r);
      mlq_pkg::rsp_type o;
      int               g;
      o = '0;
      if (r.operation == mlq_pkg::OP_ENQUEUE) begin
         if (r.priority_req >= NLev || fill[r.priority_req] >= Depth) begin
            o.dropped = 1'b1;
         end else begin
            fifo_id[r.priority_req][tail[r.priority_req]]  = r.task_id;
            fifo_rem[r.priority_req][tail[r.priority_req]] = r.remaining;
            tail[r.priority_req] = (tail[r.priority_req] + 1) % Depth;
            fill[r.priority_req]++;
         end
         return o;
      end
      for (int lv = 0; lv < NLev; lv++) begin
         if (budget[lv] == 0 || fill[lv] == 0) continue;
         g = fifo_rem[lv][head[lv]];
         if (g > budget[lv]) g = budget[lv];
         if (g > slice_max) g = slice_max;
         budget[lv] -= g;
         o.dispatched    = 1'b1;
         o.out_task_id   = fifo_id[lv][head[lv]];
         o.out_priority  = mlq_pkg::PrioWidth'(lv);
         o.granted_slice = mlq_pkg::SliceWidth'(g);
         head[lv] = (head[lv] + 1) % Depth;
         fill[lv]--;
         armed = 1'b1;
         return o;
      end
      if (armed) for (int lv = 0; lv < NLev; lv++) budget[lv] = NLev - lv;
      return o;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      mlq_pkg::rsp_type e;
      if (reset) begin
         for (int lv = 0; lv < NLev; lv++) begin
            head[lv] = 0;
            tail[lv] = 0;
            fill[lv] = 0;
            budget[lv] = NLev - lv;
         end
         armed = 1'b0;
         slice_max = mlq_pkg::SliceReset;
         expected_q.delete();
         fail_count <= 0;
         dispatch_count <= 0;
         drop_count <= 0;
      end else begin
         if (csr_valid && csr_ready) slice_max = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected item %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e !== rsp_data) begin
                  if (fail_count < 10) begin
                     $display("mismatch: exp d=%0d id=%0d pr=%0d sl=%0d dr=%0d",
                              e.dispatched, e.out_task_id, e.out_priority,
                              e.granted_slice, e.dropped);
                     $display("          got d=%0d id=%0d pr=%0d sl=%0d dr=%0d",
                              rsp_data.dispatched, rsp_data.out_task_id,
                              rsp_data.out_priority, rsp_data.granted_slice,
                              rsp_data.dropped);
                  end
                  fail_count <= fail_count + 1;
               end
               if (rsp_data.dispatched) dispatch_count <= dispatch_count + 1;
               if (rsp_data.dropped) drop_count <= drop_count + 1;
            end
         end
         if (req_valid && !req_stall) expected_q.push_back(schedule(req_data));
      end
   end
endmodule

@@ tb/testbench.sv @@
module testbench;

   localparam int ReqBits = $bits(mlq_pkg::req_type);

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   mlq_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   mlq_pkg::rsp_type               rsp_data;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [mlq_pkg::SliceWidth-1:0] csr_data;
   int                             fail_count;
   int                             pending_count;
   int                             dispatch_count;
   int                             drop_count;
   int                             cycle_count;
   int                             send_idle_pct;
   int                             stall_pct;
   int                             item_count;

   mlq_budget_scheduler_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   mlq_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .dispatch_count(dispatch_count), .drop_count(drop_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (cycle_count > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_item(input mlq_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item_count++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= mlq_pkg::req_type'(ReqBits'($urandom));
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_slice(input logic [mlq_pkg::SliceWidth-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic mlq_pkg::req_type make_enqueue(int id, int pr, int rem);
      mlq_pkg::req_type r;
      r.operation    = mlq_pkg::OP_ENQUEUE;
      r.task_id      = mlq_pkg::IdWidth'(id);
      r.priority_req = mlq_pkg::PrioWidth'(pr);
      r.remaining    = mlq_pkg::RemWidth'(rem);
      return r;
   endfunction

   function automatic mlq_pkg::req_type make_fetch();
      mlq_pkg::req_type r;
      r = mlq_pkg::req_type'(ReqBits'($urandom));
      r.operation = mlq_pkg::OP_FETCH;
      return r;
   endfunction

   function automatic mlq_pkg::req_type random_item();
      if ($urandom_range(99) < 50) return make_fetch();
      return make_enqueue($urandom_range(255), $urandom_range(7),
                          ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(12));
   endfunction

   initial begin
      int slices[6];
      cycle_count = 0;
      item_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty fetch before any dispatch, extremes, zero remaining
      send_item(make_fetch());
      send_item(make_enqueue(0, 0, 0));
      send_item(make_enqueue(255, 7, 4095));
      send_item(make_enqueue(170, 3, 1));
      send_item(make_enqueue(85, 0, 4095));
      repeat (5) send_item(make_fetch());
      for (int i = 0; i < 17; i++) send_item(make_enqueue(i, 5, 4095 - i));
      write_slice('0);
      send_item(make_fetch());
      write_slice(10'd1023);
      repeat (3) send_item(make_fetch());

      slices = '{1, 2, 1023, 3, 0, 7};
      for (int ph = 0; ph < 6; ph++) begin
         write_slice(mlq_pkg::SliceWidth'(slices[ph]));
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         repeat (160) send_item(random_item());
      end
      send_idle_pct = 0;
      stall_pct = 0;
      drain();

      $display("sent %0d items over several slice limits and idle mixes", item_count);
      $display("saw %0d dispatches and %0d drops", dispatch_count, drop_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
